// ===== rtl/core/bspq_pkg.sv =====
// bspq_pkg: widths, codes and item types of the bounded stable priority queue
// no dependencies; imported by every module of the block
package bspq_pkg;

  localparam int QUEUE_DEPTH   = 16;
  localparam int PRIORITY_BITS = 3;
  localparam int RECORD_BITS   = 64;
  localparam int FILL_BITS     = $clog2(QUEUE_DEPTH + 1);

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  typedef enum logic [1:0] {
    ST_PUSHED = 2'd0,
    ST_FULL   = 2'd1,
    ST_POPPED = 2'd2,
    ST_EMPTY  = 2'd3
  } status_t;

  typedef struct packed {
    logic                     opcode;
    logic [PRIORITY_BITS-1:0] priority_req;
    logic [RECORD_BITS-1:0]   record;
  } in_item_t;

  typedef struct packed {
    status_t                  status;
    logic [PRIORITY_BITS-1:0] out_priority;
    logic [RECORD_BITS-1:0]   out_record;
    logic [FILL_BITS-1:0]     fill_level;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic do_push;
    logic do_pop;
    logic reject;
  } dp_cmd_t;

  typedef struct packed {
    logic op_pop;
    logic full;
    logic empty;
  } dp_stat_t;

endpackage

// ===== rtl/core/bspq_datapath.sv =====
// bspq_datapath: sorted slot array with parallel compare-and-shift, fill count
// and result register; depends on bspq_pkg, driven by bspq_ctrl
module bspq_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  bspq_pkg::dp_cmd_t   cmd,
  output bspq_pkg::dp_stat_t  stat,
  input  bspq_pkg::in_item_t  in_data,
  output bspq_pkg::out_item_t out_data
);
  import bspq_pkg::*;

  logic [PRIORITY_BITS-1:0] slot_prio_r [QUEUE_DEPTH];
  logic [RECORD_BITS-1:0]   slot_rec_r  [QUEUE_DEPTH];
  logic [FILL_BITS-1:0]     count_r, count_nxt;
  logic                     op_r;
  logic [PRIORITY_BITS-1:0] prio_r;
  logic [RECORD_BITS-1:0]   rec_r;
  out_item_t                out_r;
  logic [QUEUE_DEPTH-1:0]   ge;

  assign stat.op_pop = (op_r == OP_POP);
  assign stat.full   = (count_r == FILL_BITS'(QUEUE_DEPTH));
  assign stat.empty  = (count_r == '0);
  assign out_data    = out_r;

  // entries that stay ahead of the new item
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      ge[i] = (FILL_BITS'(i) < count_r) && (slot_prio_r[i] >= prio_r);
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.do_push) begin
      count_nxt = count_r + 1'b1;
    end else if (cmd.do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_data.opcode;
      prio_r <= in_data.priority_req;
      rec_r  <= in_data.record;
    end
  end

  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_slot
    always_ff @(posedge clk) begin
      if (cmd.do_push && !ge[g]) begin
        if (g == 0) begin
          slot_prio_r[g] <= prio_r;
          slot_rec_r[g]  <= rec_r;
        end else if (ge[(g == 0) ? 0 : g-1]) begin
          slot_prio_r[g] <= prio_r;
          slot_rec_r[g]  <= rec_r;
        end else begin
          slot_prio_r[g] <= slot_prio_r[(g == 0) ? 0 : g-1];
          slot_rec_r[g]  <= slot_rec_r[(g == 0) ? 0 : g-1];
        end
      end else if (cmd.do_pop && (g < QUEUE_DEPTH-1)) begin
        slot_prio_r[g] <= slot_prio_r[(g < QUEUE_DEPTH-1) ? g+1 : g];
        slot_rec_r[g]  <= slot_rec_r[(g < QUEUE_DEPTH-1) ? g+1 : g];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.do_push || cmd.do_pop || cmd.reject) begin
      out_r.fill_level   <= count_nxt;
      out_r.out_priority <= '0;
      out_r.out_record   <= '0;
      if (cmd.do_push) begin
        out_r.status <= ST_PUSHED;
      end else if (cmd.do_pop) begin
        out_r.status       <= ST_POPPED;
        out_r.out_priority <= slot_prio_r[0];
        out_r.out_record   <= slot_rec_r[0];
      end else if (op_r == OP_POP) begin
        out_r.status <= ST_EMPTY;
      end else begin
        out_r.status <= ST_FULL;
      end
    end
  end

endmodule

// ===== rtl/core/bspq_ctrl.sv =====
// bspq_ctrl: command sequencer and handshake control of the priority queue
// depends on bspq_pkg; commands bspq_datapath
module bspq_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  bspq_pkg::dp_stat_t stat,
  output bspq_pkg::dp_cmd_t  cmd
);
  import bspq_pkg::*;

  typedef enum logic {S_IDLE, S_EXEC} state_t;

  state_t state_r;
  logic   out_valid_r;
  logic   go;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign go        = (state_r == S_EXEC) && (!out_valid_r || !out_stall);

  always_comb begin
    cmd.load    = (state_r == S_IDLE) && in_valid;
    cmd.do_push = go && !stat.op_pop && !stat.full;
    cmd.do_pop  = go && stat.op_pop && !stat.empty;
    cmd.reject  = go && (stat.op_pop ? stat.empty : stat.full);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (out_valid_r && !out_stall) begin
            out_valid_r <= 1'b0;
          end
          if (in_valid) begin
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (go) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  a_one_op: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.do_push, cmd.do_pop, cmd.reject}))
    else $error("more than one queue operation at once");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.do_push |-> !stat.full)
    else $error("push into a full queue");

  a_pop_data: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.do_pop |-> !stat.empty)
    else $error("pop from an empty queue");

  a_result_after_op: assert property (@(posedge clk) disable iff (!rst_n)
    go |=> out_valid_r && (state_r == S_IDLE))
    else $error("operation did not raise a result");

endmodule

// ===== rtl/core/bounded_stable_priority_queue.sv =====
// bounded_stable_priority_queue: top level of the sorted-array priority queue
// depends on bspq_pkg, bspq_ctrl and bspq_datapath
//
// Push and pop commands enter on the in_ channel and each gives exactly one
// item on the out_ channel. The command is first taken into a register,
// then the compare-and-shift array updates all slots at once; the result
// then sits in the output register, and the next command is taken
// while it waits. The update cycle waits only while a previous result is
// still held by out_stall. Equal priorities leave in arrival order; a push
// into a full queue and a pop of an empty one report status without change.
// No clearing pass follows reset.
module bounded_stable_priority_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  bspq_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output bspq_pkg::out_item_t out_data
);
  import bspq_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  bspq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  bspq_datapath u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .stat     (stat),
    .in_data  (in_data),
    .out_data (out_data)
  );

endmodule

// ===== test/testbench.sv =====
// testbench: self-checking bench for bounded_stable_priority_queue
// depends on bspq_pkg and the block; it predicts every result and compares field by field
// stimulus is a directed part, then random push/pop runs with idling on both sides
`timescale 1ns / 1ps

module testbench;
  import bspq_pkg::*;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  in_item_t  pending_commands[$];
  out_item_t expected_results[$];

  logic [PRIORITY_BITS-1:0] held_prio[QUEUE_DEPTH];
  logic [RECORD_BITS-1:0]   held_record[QUEUE_DEPTH];
  int held_count = 0;

  int mismatch_count = 0;
  int total_commands = 0;
  int accepted_count = 0;
  int results_seen = 0;
  logic tail_phase = 1'b0;
  logic hold_active = 1'b0;

  bounded_stable_priority_queue dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  task automatic add_command(input logic op, input logic [PRIORITY_BITS-1:0] prio,
                             input logic [RECORD_BITS-1:0] rec);
    in_item_t cmd;
    cmd.opcode = op;
    cmd.priority_req = prio;
    cmd.record = rec;
    pending_commands.push_back(cmd);
    total_commands++;
  endtask

  // sorted insert behind equal priorities, pop from the head
  task automatic apply_queue_command(input in_item_t cmd);
    out_item_t res;
    int pos;
    res = '0;
    if (cmd.opcode == OP_PUSH) begin
      if (held_count >= QUEUE_DEPTH) begin
        res.status = ST_FULL;
      end else begin
        pos = held_count;
        while (pos > 0 && held_prio[pos-1] < cmd.priority_req) begin
          held_prio[pos] = held_prio[pos-1];
          held_record[pos] = held_record[pos-1];
          pos--;
        end
        held_prio[pos] = cmd.priority_req;
        held_record[pos] = cmd.record;
        held_count++;
        res.status = ST_PUSHED;
      end
    end else begin
      if (held_count == 0) begin
        res.status = ST_EMPTY;
      end else begin
        res.out_priority = held_prio[0];
        res.out_record = held_record[0];
        for (int k = 1; k < held_count; k++) begin
          held_prio[k-1] = held_prio[k];
          held_record[k-1] = held_record[k];
        end
        held_count--;
        res.status = ST_POPPED;
      end
    end
    res.fill_level = FILL_BITS'(held_count);
    expected_results.push_back(res);
  endtask

  // driver
  always @(posedge clk) begin : drive
    int send_gap;
    bit send_idle_on;
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
      send_idle_on = 1'b1;
    end else begin
      if (in_valid && !in_stall) begin
        apply_queue_command(in_data);
        accepted_count++;
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_commands.size() == 0) begin
          in_valid <= 1'b0;
        end else if (!tail_phase && !hold_active && send_idle_on &&
                     $urandom_range(0, 3) == 0) begin
          send_gap = $urandom_range(1, 11) - 1;
          in_valid <= 1'b0;
        end else begin
          in_valid <= 1'b1;
          in_data <= pending_commands.pop_front();
        end
      end
      if ($urandom_range(0, 99) == 0) send_idle_on = !send_idle_on;
      tail_phase <= pending_commands.size() < 150;
    end
  end

  // monitor
  always @(posedge clk) begin : watch
    out_item_t want;
    int recv_gap;
    int hold_left;
    bit hold_done;
    bit recv_idle_on;
    if (!rst_n) begin
      out_stall <= 1'b0;
      recv_gap = 0;
      hold_left = 0;
      hold_done = 1'b0;
      recv_idle_on = 1'b1;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $error("unexpected item: status %0d record %h", out_data.status, out_data.out_record);
          mismatch_count++;
        end else begin
          want = expected_results.pop_front();
          if (out_data.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_data.status);
            mismatch_count++;
          end
          if (out_data.out_priority !== want.out_priority) begin
            $error("out_priority: expected %0d, actual %0d", want.out_priority,
                   out_data.out_priority);
            mismatch_count++;
          end
          if (out_data.out_record !== want.out_record) begin
            $error("out_record: expected %h, actual %h", want.out_record, out_data.out_record);
            mismatch_count++;
          end
          if (out_data.fill_level !== want.fill_level) begin
            $error("fill_level: expected %0d, actual %0d", want.fill_level,
                   out_data.fill_level);
            mismatch_count++;
          end
        end
      end
      // one long hold-off so the queue backs up into the input
      if (!hold_done && results_seen >= 400) begin
        hold_done = 1'b1;
        hold_left = 120;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_stall <= 1'b1;
      end else if (!tail_phase && recv_idle_on && $urandom_range(0, 4) == 0) begin
        recv_gap = $urandom_range(1, 11) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
      hold_active <= hold_left > 0;
      if ($urandom_range(0, 99) == 0) recv_idle_on = !recv_idle_on;
    end
  end

  initial begin
    int push_pct;
    int run_left;
    bit narrow;
    int lo;
    logic op;
    logic [PRIORITY_BITS-1:0] prio;

    // pop on empty, fill past full with ties and extremes, then drain a little
    add_command(OP_POP, {PRIORITY_BITS{1'b1}}, {RECORD_BITS{1'b1}});
    add_command(OP_PUSH, '0, '0);
    add_command(OP_PUSH, {PRIORITY_BITS{1'b1}}, {RECORD_BITS{1'b1}});
    for (int k = 2; k < QUEUE_DEPTH; k++)
      add_command(OP_PUSH, PRIORITY_BITS'((k % 3) * 3), RECORD_BITS'(k));
    add_command(OP_PUSH, {PRIORITY_BITS{1'b1}}, 64'h5a5a_a5a5_0f0f_f0f0);
    for (int k = 0; k < 4; k++)
      add_command(OP_POP, '0, '0);

    run_left = 0;
    push_pct = 50;
    narrow = 1'b0;
    lo = 0;
    for (int n = 0; n < 1100; n++) begin
      if (run_left == 0) begin
        run_left = $urandom_range(20, 60);
        case ($urandom_range(0, 2))
          0: begin
            push_pct = 25;
          end
          1: begin
            push_pct = 50;
          end
          default: begin
            push_pct = 80;
          end
        endcase
        narrow = 1'($urandom_range(0, 1));
        lo = $urandom_range(0, 6);
      end
      run_left--;
      op = ($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP;
      prio = narrow ? PRIORITY_BITS'(lo + $urandom_range(0, 1))
                    : PRIORITY_BITS'($urandom_range(0, 7));
      add_command(op, prio, {$urandom, $urandom});
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    while (accepted_count < total_commands) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/bspq_pkg.sv
rtl/core/bspq_datapath.sv
rtl/core/bspq_ctrl.sv
rtl/core/bounded_stable_priority_queue.sv
test/testbench.sv
